>>> rtl/priority_scheduler_with_throttle_core_macros.svh
// Assertion macros used by the scheduler core.
`ifndef PRIORITY_SCHEDULER_WITH_THROTTLE_CORE_MACROS_SVH
`define PRIORITY_SCHEDULER_WITH_THROTTLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psched assertion failed");
`define PSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psched assertion failed");
`else
`define PSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/psched_pkg.sv
`default_nettype none

package psched_pkg;

    localparam int PRIO_W    = 3;
    localparam int RES_W     = 8;
    localparam int WORD_W    = 64;
    localparam int IDX_OUT_W = 6;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int MOD_W     = RES_W + 1;
    localparam int MOD_CNT_W = 4;

    localparam logic [PRIO_W-1:0] IDLE_LEVEL_RST = 3'd3;
    localparam logic [PRIO_W-1:0] BG_LEVEL_RST   = 3'd2;
    localparam logic [RES_W-1:0]  THROTTLE_RST   = 8'd10;

    localparam logic ACT_CREATE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam logic [1:0] ST_CREATED  = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_SWITCHED = 2'd2;

    localparam logic [1:0] REG_IDLE_LEVEL = 2'd0;
    localparam logic [1:0] REG_BG_LEVEL   = 2'd1;
    localparam logic [1:0] REG_THROTTLE   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MOD,
        S_WB,
        S_SCAN,
        S_FETCH,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                   start;
        logic [MOD_W-1:0] dividend;
        logic [MOD_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] rem;
    } t_mod_rsp;

endpackage

`default_nettype wire

>>> rtl/psched_ram.sv
`default_nettype none

module psched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/psched_mod.sv
`default_nettype none

module psched_mod
    import psched_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mod_req i_req,
    output t_mod_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [MOD_W-1:0]     r_num;
    logic [MOD_W-1:0]     r_div;
    logic [RES_W-1:0]     r_rem;
    logic [MOD_W-1:0]     shifted;
    logic                 fits;

    // One restoring step per cycle, dividend bits taken most significant first.
    assign shifted = {r_rem, r_num[MOD_W-1]};
    assign fits    = shifted >= r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == MOD_CNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MOD_CNT_W'(MOD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - MOD_CNT_W'(1);
                if (r_cnt == MOD_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_num <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= {r_num[MOD_W-2:0], 1'b0};
            if (fits) begin
                r_rem <= RES_W'(shifted - r_div);
            end else begin
                r_rem <= shifted[RES_W-1:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

>>> rtl/priority_scheduler_with_throttle_core.sv
// Static-priority task scheduler with throttled background tasks.
// Requests enter on the input channel (i_in_valid / o_in_ready) and each one
// produces exactly one result on the output channel (o_out_valid / i_out_ready).
// A create request appends a task unless the table is full, and is answered in
// the cycle after it is accepted. A tick request saves the outgoing context,
// advances the current task's run residue, scans the task table and returns
// the chosen task. A tick updates the residue through a nine-step modulo unit,
// then scans the table, reading one priority per cycle from the table memory,
// and then fetches the chosen context and root. One request is in work at a
// time; the block is ready again once its result has been placed in the output register.
// The output register holds a result until the receiver takes it; while it is
// full and not being taken, no new request is accepted.
// Reset leaves one task, the idle task at index 0, with zero context and root,
// and loads the configuration registers with their default values.
// Configuration must be written through the APB-style port while no request
// is open; the block itself does not enforce this.
`default_nettype none
`include "priority_scheduler_with_throttle_core_macros.svh"

module priority_scheduler_with_throttle_core
    import psched_pkg::*;
#(
    parameter int MAX_TASKS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_action,
    input  wire logic [PRIO_W-1:0]    i_task_priority,
    input  wire logic [WORD_W-1:0]    i_space_root,
    input  wire logic [WORD_W-1:0]    i_context_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_status,
    output logic [IDX_OUT_W-1:0]      o_task_index,
    output logic [WORD_W-1:0]         o_context_out,
    output logic [WORD_W-1:0]         o_root_out,
    output logic                      o_load_root,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    t_state r_state;
    t_state n_state;

    logic [PRIO_W-1:0] r_idle;
    logic [PRIO_W-1:0] r_bg;
    logic [RES_W-1:0]  r_period;

    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_cur;
    logic              r_zero_ok;
    logic [CW-1:0]     r_idx;
    logic              r_pend;
    logic [IW-1:0]     r_pend_idx;
    logic [IW-1:0]     r_best;
    logic [PRIO_W-1:0] r_best_prio;
    logic [RES_W-1:0]  r_best_res;

    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [IDX_OUT_W-1:0] r_out_index;
    logic [WORD_W-1:0]    r_out_ctx;
    logic [WORD_W-1:0]    r_out_root;
    logic                 r_out_load;

    logic in_acc;
    logic out_free;
    logic is_full;
    logic issue;
    logic cfg_wr;

    logic [IW-1:0]     final_best;
    logic [RES_W-1:0]  res_cur;
    logic [MOD_W-1:0]  mod_div;
    logic [WORD_W-1:0] ctx_sel;
    logic [WORD_W-1:0] root_sel;

    logic              prio_we;
    logic [IW-1:0]     prio_waddr;
    logic [IW-1:0]     prio_raddr;
    logic [PRIO_W-1:0] prio_rdata;
    logic              ctx_we;
    logic [IW-1:0]     ctx_waddr;
    logic [WORD_W-1:0] ctx_wdata;
    logic [WORD_W-1:0] ctx_rdata;
    logic              root_we;
    logic [WORD_W-1:0] root_rdata;
    logic              res_we;
    logic [IW-1:0]     res_waddr;
    logic [RES_W-1:0]  res_wdata;
    logic [IW-1:0]     res_raddr;
    logic [RES_W-1:0]  res_rdata;

    t_mod_req mod_req;
    t_mod_rsp mod_rsp;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_full    = r_count >= CW'(MAX_TASKS);
    assign issue      = r_idx < r_count;
    assign cfg_wr     = psel && penable && pwrite && pready;

    assign final_best = ((r_best_prio == r_bg) && (r_best_res != '0)) ? '0 : r_best;
    assign res_cur    = ((r_cur == '0) && !r_zero_ok) ? '0 : res_rdata;
    assign mod_div    = (r_period == '0) ? MOD_W'(256) : MOD_W'(r_period);
    assign ctx_sel    = ((r_best == '0) && !r_zero_ok) ? '0 : ctx_rdata;
    assign root_sel   = (r_best == '0) ? '0 : root_rdata;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_action == ACT_TICK)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD:  n_state = S_MOD;
            S_MOD: begin
                if (mod_rsp.done) begin
                    n_state = S_WB;
                end
            end
            S_WB:    n_state = S_SCAN;
            S_SCAN: begin
                if (!issue && !r_pend) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        prio_we          = 1'b0;
        prio_waddr       = r_count[IW-1:0];
        prio_raddr       = r_idx[IW-1:0];
        ctx_we           = 1'b0;
        ctx_waddr        = r_cur;
        ctx_wdata        = i_context_in;
        root_we          = 1'b0;
        res_we           = 1'b0;
        res_waddr        = r_cur;
        res_wdata        = mod_rsp.rem;
        res_raddr        = r_cur;
        mod_req.start    = 1'b0;
        mod_req.dividend = MOD_W'(res_cur) + MOD_W'(1);
        mod_req.divisor  = mod_div;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_action == ACT_TICK)) begin
                    ctx_we = 1'b1;
                end else if (in_acc && !is_full) begin
                    prio_we   = 1'b1;
                    root_we   = 1'b1;
                    ctx_we    = 1'b1;
                    ctx_waddr = r_count[IW-1:0];
                    ctx_wdata = '0;
                    res_we    = 1'b1;
                    res_waddr = r_count[IW-1:0];
                    res_wdata = '0;
                end
            end
            S_LOAD:  mod_req.start = 1'b1;
            S_WB:    res_we = 1'b1;
            S_SCAN:  res_raddr = r_idx[IW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idle      <= IDLE_LEVEL_RST;
            r_bg        <= BG_LEVEL_RST;
            r_period    <= THROTTLE_RST;
            r_count     <= CW'(1);
            r_cur       <= '0;
            r_zero_ok   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_IDLE_LEVEL: r_idle   <= pwdata[PRIO_W-1:0];
                    REG_BG_LEVEL:   r_bg     <= pwdata[PRIO_W-1:0];
                    REG_THROTTLE:   r_period <= pwdata[RES_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc && (i_action == ACT_CREATE) && !is_full) begin
                r_count <= r_count + CW'(1);
            end
            if ((r_state == S_WB) && (r_cur == '0)) begin
                r_zero_ok <= 1'b1;
            end
            if (r_state == S_SCAN) begin
                r_pend <= issue;
            end else begin
                r_pend <= 1'b0;
            end
            if ((r_state == S_OUT) && out_free) begin
                r_cur <= r_best;
            end
            if ((in_acc && (i_action == ACT_CREATE)) || ((r_state == S_OUT) && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WB) begin
            r_idx       <= CW'(1);
            r_best      <= '0;
            r_best_prio <= r_idle;
            r_best_res  <= '0;
        end else if (r_state == S_SCAN) begin
            if (issue) begin
                r_idx <= r_idx + CW'(1);
            end
            r_pend_idx <= r_idx[IW-1:0];
            if (r_pend && (prio_rdata < r_best_prio)) begin
                r_best      <= r_pend_idx;
                r_best_prio <= prio_rdata;
                r_best_res  <= res_rdata;
            end
        end else if (r_state == S_FETCH) begin
            r_best <= final_best;
        end
        if (in_acc && (i_action == ACT_CREATE)) begin
            r_out_status <= is_full ? ST_FULL : ST_CREATED;
            r_out_index  <= is_full ? '0 : IDX_OUT_W'(r_count[IW-1:0]);
            r_out_ctx    <= '0;
            r_out_root   <= '0;
            r_out_load   <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_status <= ST_SWITCHED;
            r_out_index  <= IDX_OUT_W'(r_best);
            r_out_ctx    <= ctx_sel;
            r_out_root   <= root_sel;
            r_out_load   <= root_sel != '0;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_IDLE_LEVEL: prdata = PDATA_W'(r_idle);
            REG_BG_LEVEL:   prdata = PDATA_W'(r_bg);
            REG_THROTTLE:   prdata = PDATA_W'(r_period);
            default:        prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_task_index  = r_out_index;
    assign o_context_out = r_out_ctx;
    assign o_root_out    = r_out_root;
    assign o_load_root   = r_out_load;

    psched_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_TASKS)) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (prio_we),
        .i_waddr (prio_waddr),
        .i_wdata (i_task_priority),
        .i_raddr (prio_raddr),
        .o_rdata (prio_rdata)
    );

    psched_ram #(.WIDTH(WORD_W), .DEPTH(MAX_TASKS)) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (ctx_we),
        .i_waddr (ctx_waddr),
        .i_wdata (ctx_wdata),
        .i_raddr (final_best),
        .o_rdata (ctx_rdata)
    );

    psched_ram #(.WIDTH(WORD_W), .DEPTH(MAX_TASKS)) u_root_ram (
        .i_clk   (i_clk),
        .i_we    (root_we),
        .i_waddr (prio_waddr),
        .i_wdata (i_space_root),
        .i_raddr (final_best),
        .o_rdata (root_rdata)
    );

    psched_ram #(.WIDTH(RES_W), .DEPTH(MAX_TASKS)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_raddr (res_raddr),
        .o_rdata (res_rdata)
    );

    psched_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    `PSC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1,
        (r_count != '0) && (r_count <= CW'(MAX_TASKS)))
    `PSC_ASSERT_IMP(a_cur_live, i_clk, i_rst_n, 1'b1, CW'(r_cur) < r_count)
    `PSC_ASSERT_IMP(a_mod_rem, i_clk, i_rst_n, r_state == S_WB, MOD_W'(mod_rsp.rem) < mod_div)
    `PSC_ASSERT_IMP(a_best_level, i_clk, i_rst_n, (r_state == S_FETCH) && (r_best != '0),
        r_best_prio < r_idle)
    `PSC_ASSERT_NXT(a_tick_start, i_clk, i_rst_n, in_acc && (i_action == ACT_TICK),
        r_state == S_LOAD)

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

import psched_pkg::*;

localparam int TASK_SLOTS = 64;

typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  index;
    logic [63:0] ctx_word;
    logic [63:0] root;
    logic        load;
} t_sched_answer;

class sched_checker;
    logic [2:0]    idle_lvl;
    logic [2:0]    bg_lvl;
    logic [7:0]    period;
    logic [2:0]    prio_q [TASK_SLOTS];
    logic [63:0]   ctx_q [TASK_SLOTS];
    logic [63:0]   root_q [TASK_SLOTS];
    logic [7:0]    residue [TASK_SLOTS];
    int            cur;
    int            count;
    int            errors;
    t_sched_answer answer_q [$];

    function new();
        idle_lvl = IDLE_LEVEL_RST;
        bg_lvl   = BG_LEVEL_RST;
        period   = THROTTLE_RST;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            prio_q[i]  = '0;
            ctx_q[i]   = '0;
            root_q[i]  = '0;
            residue[i] = '0;
        end
        prio_q[0] = IDLE_LEVEL_RST;
        cur    = 0;
        count  = 1;
        errors = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] data);
        if (idx == REG_IDLE_LEVEL) begin
            idle_lvl = data[2:0];
        end else if (idx == REG_BG_LEVEL) begin
            bg_lvl = data[2:0];
        end else if (idx == REG_THROTTLE) begin
            period = data[7:0];
        end
    endfunction

    function void note_request(logic act, logic [2:0] pr, logic [63:0] root,
                               logic [63:0] ctx);
        t_sched_answer a;
        int            best;
        int            modulus;
        logic [2:0]    best_p;
        a = '0;
        if (act == ACT_CREATE) begin
            if (count >= TASK_SLOTS) begin
                a.status = ST_FULL;
            end else begin
                prio_q[count]  = pr;
                root_q[count]  = root;
                ctx_q[count]   = '0;
                residue[count] = '0;
                a.status = ST_CREATED;
                a.index  = 6'(count);
                count++;
            end
        end else begin
            ctx_q[cur] = ctx;
            modulus = (period == 8'd0) ? 256 : int'(period);
            residue[cur] = 8'((int'(residue[cur]) + 1) % modulus);
            best   = 0;
            best_p = idle_lvl;
            for (int i = 1; i < count; i++) begin
                if (prio_q[i] < best_p) begin
                    best_p = prio_q[i];
                    best   = i;
                end
            end
            if (best_p == bg_lvl && residue[best] != 8'd0) begin
                best = 0;
            end
            cur = best;
            a.status   = ST_SWITCHED;
            a.index    = 6'(best);
            a.ctx_word = ctx_q[best];
            a.root     = root_q[best];
            a.load     = (root_q[best] != 64'd0);
        end
        answer_q.push_back(a);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_answer(logic [1:0] st, logic [5:0] idx, logic [63:0] ctx,
                               logic [63:0] root, logic ld);
        t_sched_answer e;
        if (answer_q.size() == 0) begin
            $display("%0t: result with no request pending, expected none, actual status %0h",
                     $time, st);
            errors++;
        end else begin
            e = answer_q.pop_front();
            compare_field("status", 64'(e.status), 64'(st));
            compare_field("task_index", 64'(e.index), 64'(idx));
            compare_field("context_out", e.ctx_word, ctx);
            compare_field("root_out", e.root, root);
            compare_field("load_root", 64'(e.load), 64'(ld));
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 600000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_action;
    logic [PRIO_W-1:0]    i_task_priority;
    logic [WORD_W-1:0]    i_space_root;
    logic [WORD_W-1:0]    i_context_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_status;
    logic [IDX_OUT_W-1:0] o_task_index;
    logic [WORD_W-1:0]    o_context_out;
    logic [WORD_W-1:0]    o_root_out;
    logic                 o_load_root;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    sched_checker sb;
    bit           no_gaps = 1'b0;
    int unsigned  cycles = 0;

    priority_scheduler_with_throttle_core #(.MAX_TASKS(TASK_SLOTS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_action(i_action),
        .i_task_priority(i_task_priority),
        .i_space_root(i_space_root),
        .i_context_in(i_context_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_task_index(o_task_index),
        .o_context_out(o_context_out),
        .o_root_out(o_root_out),
        .o_load_root(o_load_root),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("priority_scheduler_with_throttle_core regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            sb.check_answer(o_status, o_task_index, o_context_out, o_root_out, o_load_root);
        end
    end

    initial begin
        int stall;
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
        end
    end

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_request(input logic act, input logic [2:0] pr,
                                input logic [63:0] root, input logic [63:0] ctx);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_task_priority <= pr;
        i_space_root    <= root;
        i_context_in    <= ctx;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        sb.note_request(act, pr, root, ctx);
    endtask

    task automatic create_task(input logic [2:0] pr, input logic [63:0] root);
        send_request(ACT_CREATE, pr, root, pick_word());
    endtask

    task automatic tick(input logic [63:0] ctx);
        send_request(ACT_TICK, 3'($urandom), pick_word(), ctx);
    endtask

    // Configuration changes only once every open request has been answered.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.answer_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        logic [31:0] data;
        data = $urandom;
        if (idx == REG_THROTTLE) begin
            data[7:0] = value;
        end else begin
            data[2:0] = value[2:0];
        end
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        sb.set_register(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int         n_items;
        logic [2:0] idle_v;
        logic [2:0] bg_v;
        logic [2:0] low_p;
        logic [7:0] period_v;
        sb = new();
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_action        <= ACT_CREATE;
        i_task_priority <= '0;
        i_space_root    <= '0;
        i_context_in    <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default configuration: the idle task, a task above the idle level, a background task.
        tick('1);
        create_task(3'd7, '1);
        create_task(3'd2, 64'd1);
        tick(64'd0);
        tick(64'hA5A5_5A5A_0F0F_F0F0);
        tick(pick_word());
        create_task(3'd0, 64'd0);
        tick(pick_word());
        create_task(3'd0, {$urandom, $urandom});
        tick(pick_word());
        drain();

        write_reg(REG_IDLE_LEVEL, 8'd0);
        tick(pick_word());
        tick(pick_word());
        drain();

        write_reg(REG_IDLE_LEVEL, 8'd7);
        write_reg(REG_BG_LEVEL, 8'd0);
        repeat (3) tick(pick_word());
        drain();

        write_reg(REG_THROTTLE, 8'd1);
        repeat (3) tick(pick_word());
        drain();

        write_reg(REG_THROTTLE, 8'd0);
        repeat (3) tick(pick_word());
        drain();

        repeat (12) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            idle_v = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(4, 7));
            bg_v = 3'($urandom_range(0, 7));
            if (sb.count > 1 && $urandom_range(0, 1) == 1) begin
                low_p = 3'd7;
                for (int i = 1; i < sb.count; i++) begin
                    if (sb.prio_q[i] < low_p) low_p = sb.prio_q[i];
                end
                bg_v = low_p;
            end
            case ($urandom_range(0, 5))
                0: period_v = 8'd0;
                1: period_v = 8'd1;
                2: period_v = 8'd255;
                3: period_v = 8'($urandom_range(2, 4));
                default: period_v = 8'($urandom_range(1, 255));
            endcase
            write_reg(REG_IDLE_LEVEL, 8'(idle_v));
            write_reg(REG_BG_LEVEL, 8'(bg_v));
            write_reg(REG_THROTTLE, period_v);
            n_items = $urandom_range(55, 75);
            repeat (n_items) begin
                if ($urandom_range(0, 99) < 15) begin
                    create_task(3'($urandom), pick_word());
                end else begin
                    tick(pick_word());
                end
            end
            drain();
        end
        no_gaps = 1'b0;

        repeat (120) @(posedge i_clk);
        if (sb.errors == 0 && sb.answer_q.size() == 0) begin
            $display("priority_scheduler_with_throttle_core regression: pass");
        end else begin
            $display("priority_scheduler_with_throttle_core regression: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire
